// ===== sv/sorted_priority_queue_macros.svh =====
// ============================================================================
// Sorted priority queue assertion macros
// Concurrent assertion helpers. They expect signals named clock and reset in
// the module that uses them, and compile to nothing under synthesis.
// ============================================================================
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sorted_priority_queue: assertion failed");

// The antecedent implies the consequent in the same cycle.
`define SPQ_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_priority_queue: assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT_ALWAYS(lbl, cond)
`define SPQ_ASSERT_IMPLIES(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/spq_pkg.sv =====
// ============================================================================
// Sorted priority queue package
// Sizes, operation and status codes, and the control word that the top level
// broadcasts to every cell of the chain.
// ============================================================================
package spq_pkg;

   // Store geometry and field widths.
   localparam int DEPTH         = 16;
   localparam int PAYLOAD_BITS  = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int COUNT_BITS    = $clog2(DEPTH + 1);
   localparam int STATUS_BITS   = 2;

   // Operation codes carried in the kind field.
   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_ENQ   = 2'd0,
      ST_DEQ   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef logic signed [PRIORITY_BITS-1:0] priority_type;
   typedef logic [PAYLOAD_BITS-1:0]         payload_type;
   typedef logic [COUNT_BITS-1:0]           count_type;

   // Operation broadcast to all cells in the cycle an item is accepted.
   typedef struct packed {
      logic         enq;
      logic         deq;
      priority_type pri;
      payload_type  pay;
   } cell_op_type;

endpackage

// ===== sv/spq_if.sv =====
// ============================================================================
// Sorted priority queue channel interfaces
// Valid/ready channels for request items and response items.
// ============================================================================
interface spq_req_if import spq_pkg::*; ();
   logic         valid;
   logic         ready;
   logic         kind;
   priority_type priority_req;
   payload_type  payload;

   modport source (output valid, output kind, output priority_req, output payload,
                   input ready);
   modport sink   (input valid, input kind, input priority_req, input payload,
                   output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   payload_type            out_payload;
   count_type              fill_count;

   modport source (output valid, output status, output out_payload, output fill_count,
                   input ready);
   modport sink   (input valid, input status, input out_payload, input fill_count,
                   output ready);
endinterface

// ===== sv/spq_cell.sv =====
// ============================================================================
// Sorted priority queue cell
// One slot of the sorted chain. On an enqueue the cell keeps its entry, takes
// the new entry, or takes its left neighbor's entry; on a dequeue it takes its
// right neighbor's entry.
// ============================================================================
module spq_cell import spq_pkg::*; (
   input  logic         clock,
   input  cell_op_type  op,
   input  logic         occupied,
   input  logic         left_stay,
   input  priority_type left_pri,
   input  payload_type  left_pay,
   input  priority_type right_pri,
   input  payload_type  right_pay,
   output logic         stay,
   output priority_type pri,
   output payload_type  pay
);

   priority_type pri_ff, pri_in;
   payload_type  pay_ff, pay_in;

   // A valid entry with a strictly smaller priority stays ahead of the new one.
   assign stay = occupied && (pri_ff < op.pri);

   // Select the next entry of this slot.
   always_comb begin
      pri_in = pri_ff;
      pay_in = pay_ff;
      if (op.enq) begin
         if (stay) begin
            pri_in = pri_ff;
            pay_in = pay_ff;
         end else if (left_stay) begin
            // Everything to the left stays, so the new entry lands here.
            pri_in = op.pri;
            pay_in = op.pay;
         end else begin
            pri_in = left_pri;
            pay_in = left_pay;
         end
      end else if (op.deq) begin
         pri_in = right_pri;
         pay_in = right_pay;
      end
   end

   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      pay_ff <= pay_in;
   end

   assign pri = pri_ff;
   assign pay = pay_ff;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ============================================================================
// Sorted priority queue
// Bounded priority queue kept sorted in a chain of cells, smallest first.
// ============================================================================
// Usage:
// Request items arrive on req_ch: kind selects enqueue or dequeue, and an
// enqueue carries a signed priority and a payload handle. Every request item
// gives exactly one response item on rsp_ch with a status, the dequeued
// payload (zero otherwise) and the number of stored entries afterward.
// A new entry goes ahead of all stored entries of equal or greater priority,
// so among equal priorities the newest leaves first. An enqueue into a full
// queue is dropped and reports full; a dequeue of an empty queue reports empty.
// The response item appears in the cycle after the request item is accepted.
// One request item is taken every cycle while the receiver keeps up, since
// all cells compare against the new priority and shift by one slot in
// parallel. When the receiver stalls, the response item holds in its
// register and no further request item is taken until it leaves. Reset
// empties the queue; stored entries need no clearing.
// ============================================================================
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
   input logic   clock,
   input logic   reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   count_type   count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   payload_type rsp_payload_ff, rsp_payload_in;
   count_type   rsp_fill_ff;

   logic        accept;
   logic        full;
   logic        empty;
   logic        is_enq;
   cell_op_type op;

   priority_type cell_pri  [DEPTH];
   payload_type  cell_pay  [DEPTH];
   logic         cell_stay [DEPTH];

   // Handshake: take a request item whenever the response slot is free or leaving.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign full   = (count_ff == COUNT_BITS'(DEPTH));
   assign empty  = (count_ff == '0);
   assign is_enq = (req_ch.kind == KIND_ENQ);

   // Broadcast the operation to the chain.
   always_comb begin
      op.enq = accept && is_enq && !full;
      op.deq = accept && !is_enq && !empty;
      op.pri = req_ch.priority_req;
      op.pay = req_ch.payload;
   end

   // The row of cells; the front of the queue is cell zero.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic         occ;
      logic         lstay;
      priority_type lpri;
      payload_type  lpay;
      priority_type rpri;
      payload_type  rpay;

      assign occ = (count_ff > COUNT_BITS'(i));

      if (i == 0) begin : g_first
         // The front cell sees a left neighbor that always stays.
         assign lstay = 1'b1;
         assign lpri  = '0;
         assign lpay  = '0;
      end else begin : g_inner
         assign lstay = cell_stay[i-1];
         assign lpri  = cell_pri[i-1];
         assign lpay  = cell_pay[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rpri = '0;
         assign rpay = '0;
      end else begin : g_body
         assign rpri = cell_pri[i+1];
         assign rpay = cell_pay[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .op        (op),
         .occupied  (occ),
         .left_stay (lstay),
         .left_pri  (lpri),
         .left_pay  (lpay),
         .right_pri (rpri),
         .right_pay (rpay),
         .stay      (cell_stay[i]),
         .pri       (cell_pri[i]),
         .pay       (cell_pay[i])
      );
   end

   // Entry count and response contents.
   always_comb begin
      count_in       = count_ff;
      rsp_status_in  = ST_ENQ;
      rsp_payload_in = '0;
      if (is_enq) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_ENQ;
            count_in      = count_ff + COUNT_BITS'(1);
         end
      end else begin
         if (empty) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_status_in  = ST_DEQ;
            rsp_payload_in = cell_pay[0];
            count_in       = count_ff - COUNT_BITS'(1);
         end
      end
   end

   // Response valid: set on accept, cleared when the receiver takes the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_fill_ff    <= count_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.out_payload = rsp_payload_ff;
   assign rsp_ch.fill_count  = rsp_fill_ff;

   // Checks on count bookkeeping and on response consistency.
   `SPQ_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_BITS'(DEPTH))
   `SPQ_ASSERT_NEXT(a_enq_grows, op.enq, count_ff == $past(count_ff) + COUNT_BITS'(1))
   `SPQ_ASSERT_NEXT(a_deq_shrinks, op.deq, count_ff == $past(count_ff) - COUNT_BITS'(1))
   `SPQ_ASSERT_IMPLIES(a_full_rsp, rsp_valid_ff && rsp_status_ff == ST_FULL,
      rsp_fill_ff == COUNT_BITS'(DEPTH) && rsp_payload_ff == '0)
   `SPQ_ASSERT_IMPLIES(a_empty_rsp, rsp_valid_ff && rsp_status_ff == ST_EMPTY,
      rsp_fill_ff == '0 && rsp_payload_ff == '0)

endmodule
